@@ design/rc_pkg.sv @@
// shared constants, types and the reciprocal table for the radix converter
package rc_pkg;

   localparam int DEPTH = 31;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int DEC_DIGITS = 10;
   localparam int DEC_W = $clog2(DEC_DIGITS + 1);
   localparam logic [31:0] DEC_RECIP = 32'hCCCC_CCCD;
   localparam logic [3:0] MAX_SRC_BASE = 4'd10;
   localparam logic [4:0] MIN_TGT_BASE = 5'd2;
   localparam logic [4:0] MAX_TGT_BASE = 5'd16;

   typedef struct packed {
      logic push;
      logic pop;
   } stack_ctl_type;

   // floor(2^32 / base) for the supported target bases
   function automatic logic [31:0] base_recip(input logic [4:0] base);
      logic [31:0] r;
      case (base)
         5'd2: r = 32'h8000_0000;
         5'd3: r = 32'h5555_5555;
         5'd4: r = 32'h4000_0000;
         5'd5: r = 32'h3333_3333;
         5'd6: r = 32'h2AAA_AAAA;
         5'd7: r = 32'h2492_4924;
         5'd8: r = 32'h2000_0000;
         5'd9: r = 32'h1C71_C71C;
         5'd10: r = 32'h1999_9999;
         5'd11: r = 32'h1745_D174;
         5'd12: r = 32'h1555_5555;
         5'd13: r = 32'h13B1_3B13;
         5'd14: r = 32'h1249_2492;
         5'd15: r = 32'h1111_1111;
         5'd16: r = 32'h1000_0000;
         default: r = 32'h8000_0000;
      endcase
      return r;
   endfunction

endpackage

@@ design/rc_cell.sv @@
// one digit cell of the remainder stack
module rc_cell
   import rc_pkg::*;
(
   input  logic          clock,
   input  stack_ctl_type ctl,
   input  logic [3:0]    upper_digit,
   input  logic [3:0]    lower_digit,
   output logic [3:0]    digit
);

   logic [3:0] digit_ff;
   logic [3:0] digit_in;

   always_comb begin
      digit_in = digit_ff;
      if (ctl.push) begin
         digit_in = upper_digit;
      end else if (ctl.pop) begin
         digit_in = lower_digit;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit = digit_ff;

endmodule

@@ design/rc_digit_stack.sv @@
// row of digit cells forming a push/pop stack, top at cell zero
module rc_digit_stack
   import rc_pkg::*;
(
   input  logic          clock,
   input  stack_ctl_type ctl,
   input  logic [3:0]    push_digit,
   output logic [3:0]    top_digit
);

   logic [3:0] cell_digit [DEPTH];

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [3:0] up;
      logic [3:0] down;
      if (g == 0) begin : g_top
         assign up = push_digit;
      end else begin : g_mid
         assign up = cell_digit[g-1];
      end
      if (g == DEPTH - 1) begin : g_bot
         assign down = 4'd0;
      end else begin : g_low
         assign down = cell_digit[g+1];
      end
      rc_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .upper_digit (up),
         .lower_digit (down),
         .digit       (cell_digit[g])
      );
   end

   assign top_digit = cell_digit[0];

endmodule

@@ design/radix_converter.sv @@
// radix converter top level: digit weighting, reciprocal division, digit stack
//
// usage
// - request channel: req_valid / req_stall, one beat carries coded_value,
//   source_base and target_base; a beat is taken when req_valid is high and
//   req_stall is low; req_stall is high while a conversion is in progress
// - response channel: rsp_valid / rsp_stall, one beat per output digit, most
//   significant first, rsp_last on the final one; a zero value gives a single
//   beat with rsp_digit_valid low and rsp_last high
// - flow: the request is taken, then each decimal digit (at most 10) is
//   weighted, then the value is divided by the target base once per output
//   digit (at most 31), then one beat leaves per cycle while rsp_stall is low;
//   the weighting and division loops are serial, one reciprocal multiply per step
// - a new request is taken once the last beat sits in the output register
// - a stalled response holds its beat; emission simply waits for the receiver
// - reset is synchronous and active high; it returns the block to idle and
//   drops rsp_valid; no clearing pass is needed, the stack is only read
//   where it was written in the same conversion
module radix_converter
   import rc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [30:0] req_coded_value,
   input  logic [3:0]  req_source_base,
   input  logic [4:0]  req_target_base,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_digit,
   output logic        rsp_digit_valid,
   output logic        rsp_last
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIG_MUL, ST_DIG_ACC, ST_DIV_MUL, ST_DIV_FIX, ST_EMIT
   } state_type;

   state_type    state_ff;
   logic [30:0]  rest_ff;
   logic [30:0]  value_ff;
   logic [30:0]  weight_ff;
   logic [3:0]   sbase_ff;
   logic [4:0]   tbase_ff;
   logic [31:0]  recip_ff;
   logic [62:0]  prod_ff;
   logic [DEC_W-1:0] ndig_ff;
   logic [CNT_W-1:0] count_ff;
   logic         rsp_valid_ff;
   logic [3:0]   rsp_digit_ff;
   logic         rsp_digit_valid_ff;
   logic         rsp_last_ff;

   // clamped request fields
   logic [3:0]   sbase_clamp;
   logic [4:0]   tbase_clamp;

   // decimal digit split, quotient by ten from the reciprocal product
   logic [27:0]  q10;
   logic [30:0]  q10_times10;
   logic [3:0]   dec_digit;

   // division by the target base with one correction step
   logic [30:0]  q_est;
   logic [30:0]  q_times_t;
   logic [30:0]  rem_raw;
   logic         rem_fix_need;
   logic [30:0]  rem_fix;
   logic [30:0]  q_fix;

   logic          out_free;
   stack_ctl_type stack_ctl;
   logic [3:0]    top_digit;

   assign sbase_clamp = (req_source_base > MAX_SRC_BASE) ? MAX_SRC_BASE : req_source_base;
   assign tbase_clamp = (req_target_base < MIN_TGT_BASE) ? MIN_TGT_BASE :
                        (req_target_base > MAX_TGT_BASE) ? MAX_TGT_BASE : req_target_base;

   assign q10         = prod_ff[62:35];
   assign q10_times10 = {q10, 3'b000} + {2'b00, q10, 1'b0};
   assign dec_digit   = 4'(rest_ff - q10_times10);

   assign q_est        = prod_ff[62:32];
   assign q_times_t    = 31'({26'd0, tbase_ff} * q_est);
   assign rem_raw      = value_ff - q_times_t;
   assign rem_fix_need = rem_raw >= {26'd0, tbase_ff};
   assign rem_fix      = rem_fix_need ? rem_raw - {26'd0, tbase_ff} : rem_raw;
   assign q_fix        = q_est + {30'd0, rem_fix_need};

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // push each remainder, pop as beats leave
   always_comb begin
      stack_ctl.push = (state_ff == ST_DIV_FIX);
      stack_ctl.pop  = (state_ff == ST_EMIT) && out_free && (count_ff != '0);
   end

   rc_digit_stack u_stack (
      .clock      (clock),
      .ctl        (stack_ctl),
      .push_digit (rem_fix[3:0]),
      .top_digit  (top_digit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         ndig_ff      <= '0;
      end else begin
         // output register drains when taken and nothing new is emitted
         if (out_free && state_ff != ST_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  rest_ff   <= req_coded_value;
                  value_ff  <= '0;
                  weight_ff <= 31'd1;
                  sbase_ff  <= sbase_clamp;
                  tbase_ff  <= tbase_clamp;
                  recip_ff  <= base_recip(tbase_clamp);
                  ndig_ff   <= '0;
                  count_ff  <= '0;
                  state_ff  <= ST_DIG_MUL;
               end
            end
            ST_DIG_MUL: begin
               // stop at the decimal digit limit or when no digits remain
               if (rest_ff == '0 || ndig_ff == DEC_W'(DEC_DIGITS)) begin
                  state_ff <= ST_DIV_MUL;
               end else begin
                  prod_ff  <= 63'(rest_ff) * 63'(DEC_RECIP);
                  state_ff <= ST_DIG_ACC;
               end
            end
            ST_DIG_ACC: begin
               value_ff  <= value_ff + 31'({27'd0, dec_digit} * weight_ff);
               weight_ff <= 31'({27'd0, sbase_ff} * weight_ff);
               rest_ff   <= {3'd0, q10};
               ndig_ff   <= ndig_ff + 1'b1;
               state_ff  <= ST_DIG_MUL;
            end
            ST_DIV_MUL: begin
               if (value_ff == '0 || count_ff == CNT_W'(DEPTH)) begin
                  state_ff <= ST_EMIT;
               end else begin
                  prod_ff  <= 63'(value_ff) * 63'(recip_ff);
                  state_ff <= ST_DIV_FIX;
               end
            end
            ST_DIV_FIX: begin
               value_ff <= q_fix;
               count_ff <= count_ff + 1'b1;
               state_ff <= ST_DIV_MUL;
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  if (count_ff == '0) begin
                     // zero value: one empty-string beat
                     rsp_digit_ff       <= 4'd0;
                     rsp_digit_valid_ff <= 1'b0;
                     rsp_last_ff        <= 1'b1;
                     state_ff           <= ST_IDLE;
                  end else begin
                     rsp_digit_ff       <= top_digit;
                     rsp_digit_valid_ff <= 1'b1;
                     rsp_last_ff        <= (count_ff == CNT_W'(1));
                     count_ff           <= count_ff - 1'b1;
                     if (count_ff == CNT_W'(1)) begin
                        state_ff <= ST_IDLE;
                     end
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digit       = rsp_digit_ff;
   assign rsp_digit_valid = rsp_digit_valid_ff;
   assign rsp_last        = rsp_last_ff;

   // the empty-string beat is always the final one
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_digit_valid_ff |-> rsp_last_ff)
      else $error("empty beat without last");

   // the stack never holds more digits than it has cells
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("digit count beyond stack depth");

   // corrected remainder is a valid digit of the target base
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV_FIX |-> rem_fix < {26'd0, tbase_ff})
      else $error("remainder not below target base");

endmodule
